FILE: rtl/hdum_pkg.sv
// ----------------------------------------------------------------------------
// hdum_pkg
// Shared types and constants for the HID descriptor usage matcher.
// ----------------------------------------------------------------------------
package hdum_pkg;

  // Header decode constants
  localparam logic [7:0] HDR_LONG_MASK = 8'hF0;
  localparam logic [7:0] HDR_SIZE_MASK = 8'h03;
  localparam logic [7:0] HDR_TAG_MASK  = 8'hFC;
  localparam logic [7:0] TAG_PAGE      = 8'h04;
  localparam logic [7:0] TAG_USAGE     = 8'h08;

  // Configuration register indexes
  localparam logic CFG_WANTED_PAGE  = 1'b0;
  localparam logic CFG_WANTED_USAGE = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER     = 2'd0,
    PH_LONG_LEN   = 2'd1,
    PH_LONG_SKIP  = 2'd2,
    PH_SHORT_DATA = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PAGE  = 2'd1,
    KIND_USAGE = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  // Parser state carried across beats
  typedef struct packed {
    phase_e      phase;
    logic [8:0]  remaining;
    kind_e       kind;
    logic [31:0] accum;
    logic [1:0]  pos;
    logic        page_seen;
    logic        usage_seen;
    logic        decided;
    logic        decided_found;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_HEADER,
    remaining:     9'd0,
    kind:          KIND_NONE,
    accum:         32'd0,
    pos:           2'd0,
    page_seen:     1'b0,
    usage_seen:    1'b0,
    decided:       1'b0,
    decided_found: 1'b0
  };

  // Verdict handed from the parser to the output stage
  typedef struct packed {
    logic valid;
    logic found;
    logic truncated;
  } result_t;

endpackage

FILE: rtl/hid_descriptor_usage_matcher_unit.sv
// ----------------------------------------------------------------------------
// hid_descriptor_usage_matcher_unit
// Scans a HID report descriptor for a configured usage page and usage.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one descriptor byte per beat in tdata[7:0];
//   tlast marks the final byte of the descriptor. Long items are skipped,
//   short Usage Page and Usage items are compared against the two config
//   registers (index 0: wanted page, index 1: wanted usage), written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
//   One verdict beat leaves on the master stream for each tlast beat:
//   tdata[0] found, tdata[1] truncated. Non-final bytes produce nothing.
//   Throughput: one byte per cycle unless a verdict is stalled in the result register.
//   The verdict is registered: it is valid the cycle after the final byte is taken.
//   When the receiver stalls with a verdict waiting in the result register,
//   s_axis_tready_o is low for every byte; it follows m_axis_tready_i, so
//   input resumes in the same cycle that the waiting verdict beat is taken.
//   Reset clears the parser state, both registers and the result valid flag;
//   after each verdict the parser restarts for the next descriptor.
// ----------------------------------------------------------------------------
module hid_descriptor_usage_matcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // descriptor byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] desc_byte
  input  logic        s_axis_tlast_i,   // final_byte
  // verdict stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [0] found, [1] truncated, [7:2] zero
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic              beat;
  logic              stage_ready;
  logic              found, truncated;
  logic [31:0]       wanted_page_q, wanted_usage_q;
  hdum_pkg::result_t result;

  assign s_axis_tready_o = stage_ready;
  assign beat            = s_axis_tvalid_i && stage_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_page_q  <= 32'd0;
      wanted_usage_q <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdum_pkg::CFG_WANTED_PAGE:  wanted_page_q  <= cfg_wdata_i;
        hdum_pkg::CFG_WANTED_USAGE: wanted_usage_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hdum_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .byte_i         (s_axis_tdata_i),
    .last_i         (s_axis_tlast_i),
    .wanted_page_i  (wanted_page_q),
    .wanted_usage_i (wanted_usage_q),
    .result_o       (result)
  );

  hdum_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .ready_o     (stage_ready),
    .valid_o     (m_axis_tvalid_o),
    .found_o     (found),
    .truncated_o (truncated),
    .ready_i     (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {6'd0, truncated, found};

  // A final byte always yields a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("final byte did not produce a verdict");

  // A verdict is never both found and truncated
  a_verdict_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("verdict reports found and truncated together");

  // Input only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a blocked verdict");

  // Non-final bytes never create or drop a verdict on their own
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(beat && s_axis_tlast_i) && !(m_axis_tvalid_o && m_axis_tready_i))
      |=> $stable(m_axis_tvalid_o))
    else $error("verdict valid changed without a cause");

endmodule

FILE: rtl/hdum_parser.sv
// ----------------------------------------------------------------------------
// hdum_parser
// Descriptor item parser: state register plus one beat of next-state logic.
// ----------------------------------------------------------------------------
module hdum_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,          // input beat accepted
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic [31:0]        wanted_page_i,
  input  logic [31:0]        wanted_usage_i,
  output hdum_pkg::result_t  result_o
);

  hdum_pkg::state_t st_q, st_d, nxt;
  logic             do_judge;
  logic [2:0]       size_bytes;

  // Compare a finished item against the wanted values
  function automatic hdum_pkg::state_t judge(input hdum_pkg::state_t s,
                                             input logic [31:0] page,
                                             input logic [31:0] usage);
    hdum_pkg::state_t r;
    r = s;
    if (s.kind == hdum_pkg::KIND_PAGE && s.accum == page) begin
      r.page_seen = 1'b1;
    end else if (s.kind == hdum_pkg::KIND_USAGE && s.accum == usage) begin
      r.usage_seen = 1'b1;
    end
    if (r.page_seen && r.usage_seen) begin
      r.decided       = 1'b1;
      r.decided_found = 1'b1;
    end
    r.kind = hdum_pkg::KIND_NONE;
    return r;
  endfunction

  // Size code 3 means four data bytes
  assign size_bytes = ((byte_i & hdum_pkg::HDR_SIZE_MASK) == 8'h03) ? 3'd4
                      : {1'b0, byte_i[1:0]};

  // Next parse state for this byte
  always_comb begin
    nxt      = st_q;
    do_judge = 1'b0;
    if (!st_q.decided) begin
      case (st_q.phase)
        hdum_pkg::PH_HEADER: begin
          if ((byte_i & hdum_pkg::HDR_LONG_MASK) == hdum_pkg::HDR_LONG_MASK) begin
            nxt.phase = hdum_pkg::PH_LONG_LEN;
            nxt.kind  = hdum_pkg::KIND_OTHER;
          end else begin
            if ((byte_i & hdum_pkg::HDR_TAG_MASK) == hdum_pkg::TAG_PAGE) begin
              nxt.kind = hdum_pkg::KIND_PAGE;
            end else if ((byte_i & hdum_pkg::HDR_TAG_MASK) == hdum_pkg::TAG_USAGE) begin
              nxt.kind = hdum_pkg::KIND_USAGE;
            end else begin
              nxt.kind = hdum_pkg::KIND_OTHER;
            end
            nxt.accum = 32'd0;
            nxt.pos   = 2'd0;
            if (size_bytes == 3'd0) begin
              do_judge = 1'b1;
            end else begin
              nxt.remaining = {6'd0, size_bytes};
              nxt.phase     = hdum_pkg::PH_SHORT_DATA;
            end
          end
        end
        hdum_pkg::PH_LONG_LEN: begin
          // tag byte plus data bytes
          nxt.remaining = {1'b0, byte_i} + 9'd1;
          nxt.phase     = hdum_pkg::PH_LONG_SKIP;
        end
        hdum_pkg::PH_LONG_SKIP: begin
          nxt.remaining = st_q.remaining - 9'd1;
          if (nxt.remaining == 9'd0) begin
            nxt.phase = hdum_pkg::PH_HEADER;
            nxt.kind  = hdum_pkg::KIND_NONE;
          end
        end
        hdum_pkg::PH_SHORT_DATA: begin
          case (st_q.pos)
            2'd0:    nxt.accum = st_q.accum | {24'd0, byte_i};
            2'd1:    nxt.accum = st_q.accum | {16'd0, byte_i, 8'd0};
            2'd2:    nxt.accum = st_q.accum | {8'd0, byte_i, 16'd0};
            default: nxt.accum = st_q.accum | {byte_i, 24'd0};
          endcase
          nxt.pos       = st_q.pos + 2'd1;
          nxt.remaining = st_q.remaining - 9'd1;
          if (nxt.remaining == 9'd0) begin
            nxt.phase = hdum_pkg::PH_HEADER;
            do_judge  = 1'b1;
          end
        end
        default: nxt = st_q;
      endcase
      if (do_judge) begin
        nxt = judge(nxt, wanted_page_i, wanted_usage_i);
      end
    end
  end

  // Verdict on the final byte; parse state restarts after it
  always_comb begin
    result_o.valid     = beat_i && last_i;
    result_o.found     = nxt.decided && nxt.decided_found;
    result_o.truncated = !nxt.decided && (nxt.phase == hdum_pkg::PH_SHORT_DATA) &&
                         (nxt.kind == hdum_pkg::KIND_PAGE ||
                          nxt.kind == hdum_pkg::KIND_USAGE);
    st_d = st_q;
    if (beat_i) begin
      st_d = last_i ? hdum_pkg::STATE_RESET : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hdum_pkg::STATE_RESET;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

FILE: rtl/hdum_out_stage.sv
// ----------------------------------------------------------------------------
// hdum_out_stage
// Result register between the parser and the output stream.
// ----------------------------------------------------------------------------
module hdum_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hdum_pkg::result_t  result_i,
  output logic               ready_o,    // room for a new verdict this cycle
  output logic               valid_o,
  output logic               found_o,
  output logic               truncated_o,
  input  logic               ready_i
);

  logic valid_q, valid_d;
  logic found_q, truncated_q;

  // Register is free when empty or being drained
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      found_q     <= result_i.found;
      truncated_q <= result_i.truncated;
    end
  end

  assign valid_o     = valid_q;
  assign found_o     = found_q;
  assign truncated_o = truncated_q;

endmodule

FILE: bench/tb_hid_descriptor_usage_matcher_unit.sv
// ----------------------------------------------------------------------------
// tb_hid_descriptor_usage_matcher_unit
// Self-checking bench for the HID descriptor usage matcher. A short table of
// hand-built descriptors comes first. Random descriptors follow: well-formed
// item chains, chains cut short, and raw noise. Each random phase uses its own
// match values and one of four handshake pacings. A local parser model predicts
// each verdict beat, and every beat on the master side is checked against it.
// ----------------------------------------------------------------------------
module tb_hid_descriptor_usage_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 3000;  // cycles without any beat
  localparam int SETTLE_TICKS = 4;     // verdict is out the cycle after tlast
  localparam int PHASE_BYTES  = 120;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    logic found;
    logic truncated;
  } verdict_t;

  // one row of the directed table; typed rows carry their own verdict
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic       found;
    logic       trunc;
  } stim_row_t;

  typedef enum int {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_idx_i       = hdum_pkg::CFG_WANTED_PAGE;
  logic [31:0] cfg_wdata_i     = 32'h0;

  hid_descriptor_usage_matcher_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] desc_byte
    .s_axis_tlast_i  (s_axis_tlast_i),   // final_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [0] found, [1] truncated, [7:2] zero
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // pending verdicts, oldest first
  verdict_t   verdict_q[$];
  logic [7:0] desc_bytes[$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;

  // parser model state
  hdum_pkg::phase_e cur_phase;
  logic [8:0]       owed;
  hdum_pkg::kind_e  cur_kind;
  logic [31:0]      accum;
  logic [1:0]       byte_idx;
  logic             page_hit, usage_hit, done, done_found;
  logic [31:0]      match_page, match_usage;

  // hand-built descriptors, match values page 0x01 / usage 0x06
  stim_row_t directed_rows [25] = '{
    // page + usage hit, trailing bytes ignored
    '{8'h05, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h09, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hA1, 1'b1, 1'b1, 1'b1, 1'b0},
    // page item cut off
    '{8'h06, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h34, 1'b1, 1'b1, 1'b0, 1'b1},
    // long item, zero-data page/usage, 4-byte usage of all ones
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h04, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h08, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h0B, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
    // other short item cut off
    '{8'h26, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
    // long item cut at its header
    '{8'hFE, 1'b1, 1'b1, 1'b0, 1'b0},
    // usage item cut at its header
    '{8'h09, 1'b1, 1'b1, 1'b0, 1'b1},
    // page hit, then usage cut off
    '{8'h05, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h0A, 1'b0, 1'b0, 1'b0, 1'b0}, '{8'h06, 1'b1, 1'b1, 1'b0, 1'b1}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  task automatic restart_descriptor();
    cur_phase  = hdum_pkg::PH_HEADER;
    owed       = '0;
    cur_kind   = hdum_pkg::KIND_NONE;
    accum      = '0;
    byte_idx   = '0;
    page_hit   = 1'b0;
    usage_hit  = 1'b0;
    done       = 1'b0;
    done_found = 1'b0;
  endtask

  // compare a finished page/usage item with the match values
  task automatic close_item();
    if (cur_kind == hdum_pkg::KIND_PAGE && accum == match_page)
      page_hit = 1'b1;
    else if (cur_kind == hdum_pkg::KIND_USAGE && accum == match_usage)
      usage_hit = 1'b1;
    if (page_hit && usage_hit) begin
      done       = 1'b1;
      done_found = 1'b1;
    end
    cur_kind = hdum_pkg::KIND_NONE;
  endtask

  task automatic advance_parser(input logic [7:0] b);
    logic [2:0] n;
    case (cur_phase)
      hdum_pkg::PH_HEADER: begin
        if ((b & hdum_pkg::HDR_LONG_MASK) == hdum_pkg::HDR_LONG_MASK) begin
          cur_phase = hdum_pkg::PH_LONG_LEN;
          cur_kind  = hdum_pkg::KIND_OTHER;
        end else begin
          n = ((b & hdum_pkg::HDR_SIZE_MASK) == hdum_pkg::HDR_SIZE_MASK)
              ? 3'd4 : {1'b0, b[1:0]};
          if ((b & hdum_pkg::HDR_TAG_MASK) == hdum_pkg::TAG_PAGE)
            cur_kind = hdum_pkg::KIND_PAGE;
          else if ((b & hdum_pkg::HDR_TAG_MASK) == hdum_pkg::TAG_USAGE)
            cur_kind = hdum_pkg::KIND_USAGE;
          else
            cur_kind = hdum_pkg::KIND_OTHER;
          accum    = '0;
          byte_idx = '0;
          if (n == 3'd0) begin
            close_item();
          end else begin
            owed      = {6'd0, n};
            cur_phase = hdum_pkg::PH_SHORT_DATA;
          end
        end
      end
      hdum_pkg::PH_LONG_LEN: begin
        // tag byte plus data bytes
        owed      = {1'b0, b} + 9'd1;
        cur_phase = hdum_pkg::PH_LONG_SKIP;
      end
      hdum_pkg::PH_LONG_SKIP: begin
        owed = owed - 9'd1;
        if (owed == '0) begin
          cur_phase = hdum_pkg::PH_HEADER;
          cur_kind  = hdum_pkg::KIND_NONE;
        end
      end
      default: begin
        accum    = accum | (32'(b) << (8 * byte_idx));
        byte_idx = byte_idx + 2'd1;
        owed     = owed - 9'd1;
        if (owed == '0) begin
          cur_phase = hdum_pkg::PH_HEADER;
          close_item();
        end
      end
    endcase
  endtask

  task automatic scan_descriptor_byte(input logic [7:0] b, input logic last,
                                      output logic has_verdict, output verdict_t v);
    has_verdict = 1'b0;
    v           = '0;
    if (!done)
      advance_parser(b);
    if (last) begin
      has_verdict = 1'b1;
      if (done)
        v.found = done_found;
      else if (cur_phase == hdum_pkg::PH_SHORT_DATA &&
               (cur_kind == hdum_pkg::KIND_PAGE || cur_kind == hdum_pkg::KIND_USAGE))
        v.truncated = 1'b1;
      restart_descriptor();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_pace(input pace_e p);
    case (p)
      PACE_SEND_IDLE:  begin send_idle_pct = 67; stall_pct = 0;  end
      PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 67; end
      PACE_BOTH:       begin send_idle_pct = 20; stall_pct = 20; end
      default:         begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // both match values, back to back; block must be idle
  task automatic load_match_values(input logic [31:0] page, input logic [31:0] usage);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= hdum_pkg::CFG_WANTED_PAGE;
    cfg_wdata_i <= page;
    @(posedge clk_i);
    cfg_idx_i   <= hdum_pkg::CFG_WANTED_USAGE;
    cfg_wdata_i <= usage;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    match_page  = page;
    match_usage = usage;
  endtask

  // one byte beat, with random idle cycles ahead of it
  task automatic send_desc_byte(input logic [7:0] b, input logic last,
                                input logic typed, input verdict_t typed_v);
    logic     has_verdict;
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom_range(255));
      s_axis_tlast_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    scan_descriptor_byte(b, last, has_verdict, v);
    if (has_verdict)
      verdict_q.push_back(typed ? typed_v : v);
  endtask

  // hold the sender until every verdict is back, then let the block settle
  task automatic settle_idle();
    s_axis_tvalid_i <= 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // random descriptor: mostly item chains, some cut short, some noise
  task automatic build_descriptor();
    int          sel, sz, nbytes, len;
    logic        want_hit;
    logic [31:0] val;
    logic [7:0]  hdr;
    desc_bytes.delete();
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 8)) desc_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      sel      = $urandom_range(0, 9);
      sz       = $urandom_range(0, 3);
      want_hit = 1'($urandom_range(1));
      if (sel < 7) begin
        if (sel < 3) begin
          val = want_hit ? match_page : $urandom;
          hdr = hdum_pkg::TAG_PAGE;
        end else if (sel < 6) begin
          val = want_hit ? match_usage : $urandom;
          hdr = hdum_pkg::TAG_USAGE;
        end else begin
          want_hit = 1'b0;
          val      = $urandom;
          do hdr = 8'($urandom_range(255));
          while ((hdr & hdum_pkg::HDR_LONG_MASK) == hdum_pkg::HDR_LONG_MASK ||
                 (hdr & hdum_pkg::HDR_TAG_MASK) == hdum_pkg::TAG_PAGE ||
                 (hdr & hdum_pkg::HDR_TAG_MASK) == hdum_pkg::TAG_USAGE);
          hdr = hdr & hdum_pkg::HDR_TAG_MASK;
        end
        if (want_hit && val > 32'hFFFF)
          sz = 3;
        nbytes = (sz == 3) ? 4 : sz;
        desc_bytes.push_back(hdr | 8'(sz));
        for (int i = 0; i < nbytes; i++)
          desc_bytes.push_back(val[8*i +: 8]);
      end else begin
        // long item: mostly short bodies, now and then a big one
        len = ($urandom_range(19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        desc_bytes.push_back({4'hF, 4'($urandom_range(15))});
        desc_bytes.push_back(8'(len));
        desc_bytes.push_back(8'($urandom_range(255)));
        repeat (len) desc_bytes.push_back(8'($urandom_range(255)));
      end
    end
    // cut the chain at a random byte
    if ($urandom_range(99) < 15 && desc_bytes.size() > 1)
      repeat ($urandom_range(1, desc_bytes.size() - 1)) void'(desc_bytes.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing
  // ---------------------------------------------------------------------------
  always @(posedge clk_i)
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // Verdict check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : verdict_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (verdict_q.size() == 0) begin
        $error("verdict beat with none pending: tdata=%h", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata_o[0] !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_axis_tdata_o[0]);
          mismatches++;
        end
        if (m_axis_tdata_o[1] !== want.truncated) begin
          $error("truncated: expected %0b, got %0b", want.truncated, m_axis_tdata_o[1]);
          mismatches++;
        end
        if (m_axis_tdata_o[7:2] !== 6'd0) begin
          $error("pad: expected 0, got %h", m_axis_tdata_o[7:2]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no beat on either side for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          sent;
    logic [31:0] pg, us;
    match_page  = '0;
    match_usage = '0;
    restart_descriptor();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed descriptors, no idling
    set_pace(PACE_FREE);
    load_match_values(32'h0000_0001, 32'h0000_0006);
    foreach (directed_rows[i])
      send_desc_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                     verdict_t'({directed_rows[i].found, directed_rows[i].trunc}));

    // random phases, each with its own match values and one of four pacings
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      set_pace(pace_e'(p % 4));
      case (p)
        0:       begin pg = 32'h0000_0000; us = 32'h0000_0000; end
        1:       begin pg = 32'hFFFF_FFFF; us = 32'hFFFF_FFFF; end
        2:       begin pg = 32'h0000_000C; us = 32'h0000_0001; end
        3:       begin pg = $urandom_range(0, 255); us = $urandom_range(0, 255); end
        4:       begin pg = $urandom; us = $urandom; end
        5:       begin pg = 32'h0000_FFFF; us = 32'h0000_0000; end
        6:       begin pg = 32'h0000_0001; us = 32'h0000_0002; end
        default: begin pg = $urandom_range(0, 65535); us = $urandom_range(0, 65535); end
      endcase
      load_match_values(pg, us);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_descriptor();
        if ($urandom_range(99) < 3)
          settle_idle();
        for (int i = 0; i < desc_bytes.size(); i++)
          send_desc_byte(desc_bytes[i], i == desc_bytes.size() - 1, 1'b0, '0);
        sent += desc_bytes.size();
      end
    end

    settle_idle();
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
